### hw/rtl/kss_pkg.sv
// Shared constants, types and the base decoder for the seed key stream.
package kss_pkg;

  localparam int MAX_KMER  = 32;
  localparam int WIN_W     = 2 * MAX_KMER;
  localparam int CHAR_W    = 8;
  localparam int KLEN_W    = 6;
  localparam int CONV_W    = 2;
  localparam int MOD_W     = 33;
  localparam int REM_W     = MOD_W;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 32;
  localparam int CNT_W     = $clog2(WIN_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = MOD_W;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS    = 2'd2;

  localparam logic [CONV_W-1:0] CONV_C_TO_T = 2'd1;
  localparam logic [CONV_W-1:0] CONV_G_TO_A = 2'd2;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [CHAR_W-1:0] SKIP_BELOW = 8'd33;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(MAX_KMER);
  localparam logic [MOD_W-1:0]  MOD_RESET  = 33'd536870911;
  localparam logic [MOD_W-1:0]  MOD_ZERO_AS = 33'h1_0000_0000;

  typedef struct packed {
    logic take;
    logic step;
    logic publish;
  } kss_cmd_t;

  typedef struct packed {
    logic hit;
    logic div_last;
    logic out_free;
  } kss_sts_t;

  // Returns {unknown, code}.
  function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch,
                                           input logic [CONV_W-1:0] mode);
    logic [1:0] c;
    logic       unk;
    c   = BASE_A;
    unk = 1'b0;
    case (ch)
      "A", "a": c = BASE_A;
      "C", "c": c = BASE_C;
      "G", "g": c = BASE_G;
      "T", "t": c = BASE_T;
      default:  unk = 1'b1;
    endcase
    case (mode)
      CONV_C_TO_T: if (c == BASE_C) c = BASE_T;
      CONV_G_TO_A: if (c == BASE_G) c = BASE_A;
      default: ;
    endcase
    return {unk, c};
  endfunction

endpackage

### hw/rtl/kss_ifs.sv
// Channel interfaces: reference characters in, seed keys out, register writes.
interface kss_in_if;
  logic                         valid;
  logic                         ready;
  logic [kss_pkg::CHAR_W-1:0]   base_char;
  modport source (output valid, base_char, input ready);
  modport sink   (input valid, base_char, output ready);
endinterface

interface kss_out_if;
  logic                         valid;
  logic                         ready;
  logic [kss_pkg::KEY_W-1:0]    seed_key;
  logic [kss_pkg::POS_W-1:0]    seed_position;
  modport source (output valid, seed_key, seed_position, input ready);
  modport sink   (input valid, seed_key, seed_position, output ready);
endinterface

interface kss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kss_pkg::CFG_IDX_W-1:0]   index;
  logic [kss_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/kss_ctrl.sv
// Controller: sequences item intake, the remainder loop and result hand-off.
module kss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kss_pkg::kss_sts_t sts,
  output kss_pkg::kss_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && sts.hit) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the remainder until the output register is free
        cmd.publish = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/kss_dpath.sv
// Datapath: config registers, base window, counters, remainder unit and output register.
module kss_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [kss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kss_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic [kss_pkg::CHAR_W-1:0]      in_base_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kss_pkg::KEY_W-1:0]       out_seed_key,
  output logic [kss_pkg::POS_W-1:0]       out_seed_position,
  input  kss_pkg::kss_cmd_t               cmd,
  output kss_pkg::kss_sts_t               sts
);

  logic [kss_pkg::KLEN_W-1:0] kmer_length_r;
  logic [kss_pkg::CONV_W-1:0] conversion_mode_r;
  logic [kss_pkg::MOD_W-1:0]  hash_modulus_r;

  logic [kss_pkg::WIN_W-1:0]  window_r, window_nxt;
  logic [kss_pkg::KLEN_W-1:0] run_r, run_nxt;
  logic [kss_pkg::POS_W-1:0]  count_r;

  logic [kss_pkg::WIN_W-1:0]  div_sh_r;
  logic [kss_pkg::CNT_W-1:0]  div_cnt_r;
  logic [kss_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [kss_pkg::POS_W-1:0]  pos_r;

  logic                       out_valid_r;
  logic [kss_pkg::KEY_W-1:0]  key_r;
  logic [kss_pkg::POS_W-1:0]  opos_r;

  logic [2:0]                 code;
  logic                       skip, known;
  logic [kss_pkg::KLEN_W-1:0] k_eff;
  logic [kss_pkg::CNT_W-1:0]  two_k, align_sh;
  logic [kss_pkg::MOD_W-1:0]  mod_eff;
  logic [kss_pkg::REM_W:0]    rem_sh;

  assign skip  = in_base_char < kss_pkg::SKIP_BELOW;
  assign code  = kss_pkg::base_code(in_base_char, conversion_mode_r);
  assign known = !code[2];

  always_comb begin
    k_eff = kmer_length_r;
    if (kmer_length_r == '0 || kmer_length_r > kss_pkg::KLEN_W'(kss_pkg::MAX_KMER))
      k_eff = kss_pkg::KLEN_W'(kss_pkg::MAX_KMER);
  end

  assign two_k    = {k_eff, 1'b0};
  assign align_sh = kss_pkg::CNT_W'(kss_pkg::WIN_W) - two_k;
  assign mod_eff  = (hash_modulus_r == '0) ? kss_pkg::MOD_ZERO_AS : hash_modulus_r;

  assign window_nxt = {window_r[kss_pkg::WIN_W-3:0], known ? code[1:0] : 2'b00};

  always_comb begin
    run_nxt = '0;
    if (known) begin
      run_nxt = run_r;
      if (run_r < kss_pkg::KLEN_W'(kss_pkg::MAX_KMER)) run_nxt = run_r + 1'b1;
    end
  end

  assign sts.hit = !skip && known && (run_nxt >= k_eff);

  // one quotient bit per step: shift in, compare, subtract
  assign rem_sh = {rem_r, div_sh_r[kss_pkg::WIN_W-1]};
  always_comb begin
    rem_nxt = rem_sh[kss_pkg::REM_W-1:0];
    if (rem_sh >= {1'b0, mod_eff})
      rem_nxt = kss_pkg::REM_W'(rem_sh - {1'b0, mod_eff});
  end

  assign sts.div_last = (div_cnt_r == kss_pkg::CNT_W'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r     <= kss_pkg::KLEN_RESET;
      conversion_mode_r <= '0;
      hash_modulus_r    <= kss_pkg::MOD_RESET;
      window_r          <= '0;
      run_r             <= '0;
      count_r           <= '0;
      div_cnt_r         <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          kss_pkg::REG_KMER_LENGTH:     kmer_length_r     <= cfg_data[kss_pkg::KLEN_W-1:0];
          kss_pkg::REG_CONVERSION_MODE: conversion_mode_r <= cfg_data[kss_pkg::CONV_W-1:0];
          kss_pkg::REG_HASH_MODULUS:    hash_modulus_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take && !skip) begin
        window_r <= window_nxt;
        run_r    <= run_nxt;
        count_r  <= count_r + 1'b1;
      end
      if (cmd.take) begin
        div_cnt_r <= two_k;
      end else if (cmd.step) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      // left-align the window so its oldest base leads the bit stream
      div_sh_r <= window_nxt << align_sh;
      rem_r    <= '0;
      pos_r    <= count_r - kss_pkg::POS_W'(k_eff - 1'b1);
    end else if (cmd.step) begin
      div_sh_r <= {div_sh_r[kss_pkg::WIN_W-2:0], 1'b0};
      rem_r    <= rem_nxt;
    end
    if (cmd.publish) begin
      key_r  <= rem_r[kss_pkg::KEY_W-1:0];
      opos_r <= pos_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seed_key      = key_r;
  assign out_seed_position = opos_r;

endmodule

### hw/rtl/kmer_seed_key_stream.sv
// Top level of the k-mer seed key stream.
//
// in_ch carries one reference character per item. Characters below 33 are
// dropped; other characters are bases (A/C/G/T either case, anything else an
// unknown base). out_ch carries one seed key and the window's first base
// position each time the last kmer_length bases are all known. cfg_ch writes
// kmer_length (index 0), conversion_mode (index 1) and hash_modulus (index 2)
// and is always ready; write it only while no item is in flight.
//
// An item that gives no result leaves in_ch.ready high. For an item that
// gives a result, the key is reduced one window bit per cycle by a single
// compare-and-subtract unit, and in_ch.ready stays low meanwhile. The result
// sits in an output register, so the next item is taken while it waits.
//
// A stalled receiver holds the result steady; a further result waits in the
// remainder unit until the output register frees. Synchronous reset clears
// the window, counters and output valid and restores register defaults
// (k = 32, no conversion, modulus 536870911).
module kmer_seed_key_stream (
  input  logic   clk,
  input  logic   rst_n,
  kss_in_if.sink     in_ch,
  kss_out_if.source  out_ch,
  kss_cfg_if.sink    cfg_ch
);

  kss_pkg::kss_cmd_t cmd;
  kss_pkg::kss_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  kss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kss_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .in_base_char      (in_ch.base_char),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_seed_key      (out_ch.seed_key),
    .out_seed_position (out_ch.seed_position),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

### hw/rtl/kss_checker.sv
// Port-level checks for the seed key stream, bound to the top level.
module kss_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [kss_pkg::CHAR_W-1:0]    in_base_char,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kss_pkg::KEY_W-1:0]     out_seed_key,
  input logic [kss_pkg::POS_W-1:0]     out_seed_position,
  input logic                          cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seed_key)
                                && $stable(out_seed_position))
    else $error("result changed while stalled");

  // a dropped character never blocks intake
  a_skip_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_base_char < kss_pkg::SKIP_BELOW) |=> in_ready)
    else $error("skipped character stalled intake");

  // results appear only at the end of a reduction, which blocks intake
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result without a preceding reduction");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind kmer_seed_key_stream kss_checker u_kss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_base_char      (in_ch.base_char),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_seed_key      (out_ch.seed_key),
  .out_seed_position (out_ch.seed_position),
  .cfg_ready         (cfg_ch.ready)
);

### verif/kmer_seed_key_stream_test.sv
// Self-checking testbench for kmer_seed_key_stream: directed and random streams with checks.
module kmer_seed_key_stream_test;

  localparam logic [kss_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [kss_pkg::CONV_W-1:0]    CONV_NONE   = 2'd0;
  localparam logic [kss_pkg::CONV_W-1:0]    CONV_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [kss_pkg::KEY_W-1:0] key;
    logic [kss_pkg::POS_W-1:0] pos;
  } seed_t;

  typedef struct packed {
    logic       unknown;
    logic [1:0] code;
  } base_t;

  logic clk;
  logic rst_n;

  kss_in_if  in_ch();
  kss_out_if out_ch();
  kss_cfg_if cfg_ch();

  kmer_seed_key_stream dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadows and window state of the predictor
  logic [kss_pkg::KLEN_W-1:0] klen_cfg;
  logic [kss_pkg::CONV_W-1:0] conv_cfg;
  logic [kss_pkg::MOD_W-1:0]  modulus_cfg;
  logic [kss_pkg::WIN_W-1:0]  window;
  int                         clean_run;
  logic [kss_pkg::POS_W-1:0]  base_total;

  seed_t seed_q[$];
  int    errors;
  int    idle_cycles;
  int    hold_cycles;
  int    recv_stall;
  bit    no_idle;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic base_t decode_char(input logic [kss_pkg::CHAR_W-1:0] ch,
                                        input logic [kss_pkg::CONV_W-1:0] mode);
    base_t b;
    b.unknown = 1'b0;
    // fold upper case onto lower case; only letters land on a/c/g/t
    case (ch | 8'h20)
      "a": b.code = kss_pkg::BASE_A;
      "c": b.code = kss_pkg::BASE_C;
      "g": b.code = kss_pkg::BASE_G;
      "t": b.code = kss_pkg::BASE_T;
      default: begin
        b.unknown = 1'b1;
        b.code    = kss_pkg::BASE_A;
      end
    endcase
    if (mode == kss_pkg::CONV_C_TO_T && b.code == kss_pkg::BASE_C) b.code = kss_pkg::BASE_T;
    else if (mode == kss_pkg::CONV_G_TO_A && b.code == kss_pkg::BASE_G)
      b.code = kss_pkg::BASE_A;
    return b;
  endfunction

  function automatic int eff_kmer();
    if (klen_cfg == '0 || klen_cfg > kss_pkg::KLEN_W'(kss_pkg::MAX_KMER))
      return kss_pkg::MAX_KMER;
    return int'(klen_cfg);
  endfunction

  // Advance the window model by one item and queue the seed it yields, if any.
  function automatic void track_base(input logic [kss_pkg::CHAR_W-1:0] ch);
    base_t                     b;
    int                        k;
    logic [kss_pkg::WIN_W-1:0] mask;
    logic [kss_pkg::WIN_W-1:0] win_bits;
    logic [kss_pkg::WIN_W-1:0] rem;
    logic [kss_pkg::MOD_W-1:0] m;
    logic [kss_pkg::POS_W-1:0] first;
    seed_t                     s;
    if (ch < kss_pkg::SKIP_BELOW) return;
    b = decode_char(ch, conv_cfg);
    first = base_total;
    base_total = base_total + 1'b1;
    if (b.unknown) begin
      window = window << 2;
      clean_run = 0;
      return;
    end
    window = (window << 2) | kss_pkg::WIN_W'(b.code);
    if (clean_run < kss_pkg::MAX_KMER) clean_run++;
    k = eff_kmer();
    if (clean_run < k) return;
    mask = (k >= kss_pkg::MAX_KMER) ? '1 :
           ((kss_pkg::WIN_W'(1) << (2 * k)) - kss_pkg::WIN_W'(1));
    win_bits = window & mask;
    m = (modulus_cfg == '0) ? kss_pkg::MOD_ZERO_AS : modulus_cfg;
    rem = win_bits % kss_pkg::WIN_W'(m);
    s.key = rem[kss_pkg::KEY_W-1:0];
    s.pos = first - kss_pkg::POS_W'(k - 1);
    seed_q = {seed_q, s};
  endfunction

  task automatic send_char(input logic [kss_pkg::CHAR_W-1:0] ch);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.base_char = ch;
    do @(posedge clk); while (!in_ch.ready);
    track_base(ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid, let every queued seed arrive, then give the remainder unit time to finish.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (seed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kss_pkg::CFG_DAT_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      kss_pkg::REG_KMER_LENGTH:     klen_cfg    = data[kss_pkg::KLEN_W-1:0];
      kss_pkg::REG_CONVERSION_MODE: conv_cfg    = data[kss_pkg::CONV_W-1:0];
      kss_pkg::REG_HASH_MODULUS:    modulus_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [kss_pkg::CHAR_W-1:0] pick_char(input int noise_pct);
    string letters = "ACGTacgt";
    int    r;
    r = $urandom_range(0, 99);
    if (r < noise_pct) return kss_pkg::CHAR_W'($urandom_range(0, 255));
    if (r < noise_pct + 4) return kss_pkg::CHAR_W'($urandom_range(0, 32));
    return letters[$urandom_range(0, 7)];
  endfunction

  function automatic logic [kss_pkg::CFG_DAT_W-1:0] rand_data();
    return {1'($urandom_range(0, 1)), 32'($urandom())};
  endfunction

  task automatic run_phase(input logic [kss_pkg::CFG_DAT_W-1:0] kdata,
                           input logic [kss_pkg::CFG_DAT_W-1:0] cdata,
                           input logic [kss_pkg::CFG_DAT_W-1:0] mdata, input int n,
                           input bit quiet);
    int noise;
    write_reg(kss_pkg::REG_KMER_LENGTH, kdata);
    write_reg(kss_pkg::REG_CONVERSION_MODE, cdata);
    write_reg(kss_pkg::REG_HASH_MODULUS, mdata);
    // long windows need long clean runs to give any seeds
    noise = (eff_kmer() > 16) ? 2 : 10;
    no_idle = quiet;
    repeat (n) send_char(pick_char(noise));
    no_idle = 1'b0;
  endtask

  task automatic test_base_decoding();
    write_reg(kss_pkg::REG_KMER_LENGTH, kss_pkg::CFG_DAT_W'(1));
    write_reg(kss_pkg::REG_HASH_MODULUS, '0);
    write_reg(kss_pkg::REG_CONVERSION_MODE, kss_pkg::CFG_DAT_W'(CONV_UNUSED));
    write_reg(REG_UNUSED, 33'h1_2345_6789);
    send_char(8'd0);
    send_char(8'd32);
    send_text("AcGt");
    send_text("N");
    send_char(8'd255);
    send_char(8'd128);
    send_text("!T");
  endtask

  task automatic test_conversion();
    write_reg(kss_pkg::REG_CONVERSION_MODE, kss_pkg::CFG_DAT_W'(kss_pkg::CONV_C_TO_T));
    send_text("CcG");
    write_reg(kss_pkg::REG_CONVERSION_MODE, kss_pkg::CFG_DAT_W'(kss_pkg::CONV_G_TO_A));
    send_text("GgC");
    write_reg(kss_pkg::REG_CONVERSION_MODE, kss_pkg::CFG_DAT_W'(CONV_NONE));
  endtask

  task automatic test_kmer_change();
    write_reg(kss_pkg::REG_KMER_LENGTH, kss_pkg::CFG_DAT_W'(3));
    write_reg(kss_pkg::REG_HASH_MODULUS, 33'h1_FFFF_FFFF);
    send_text("ACGT");
    // shorter window reuses the bases already held
    write_reg(kss_pkg::REG_KMER_LENGTH, kss_pkg::CFG_DAT_W'(2));
    send_text("a");
  endtask

  task automatic test_output_backpressure();
    write_reg(kss_pkg::REG_KMER_LENGTH, kss_pkg::CFG_DAT_W'(1));
    write_reg(kss_pkg::REG_HASH_MODULUS, kss_pkg::CFG_DAT_W'($urandom_range(1, 1000)));
    no_idle = 1'b1;
    hold_cycles = HOLD_CYCLES;
    repeat (40) send_char(pick_char(0));
    no_idle = 1'b0;
  endtask

  task automatic test_random_streams();
    logic [kss_pkg::CFG_DAT_W-1:0] mdata;
    int                            sel;
    run_phase('0, kss_pkg::CFG_DAT_W'(CONV_NONE), 33'h1_FFFF_FFFF, 150, 1'b0);
    run_phase(33'h1_FFFF_FFE1, kss_pkg::CFG_DAT_W'(CONV_UNUSED), '0, 150, 1'b0);
    run_phase(kss_pkg::CFG_DAT_W'(63), kss_pkg::CFG_DAT_W'(kss_pkg::CONV_C_TO_T),
              kss_pkg::CFG_DAT_W'(1), 100, 1'b0);
    run_phase(kss_pkg::CFG_DAT_W'(1), kss_pkg::CFG_DAT_W'(kss_pkg::CONV_G_TO_A),
              kss_pkg::MOD_ZERO_AS, 150, 1'b1);
    for (int i = 0; i < 6; i++) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) mdata = kss_pkg::CFG_DAT_W'($urandom_range(1, 1000));
      else if (sel == 1) mdata = kss_pkg::CFG_DAT_W'($urandom());
      else mdata = rand_data();
      run_phase(kss_pkg::CFG_DAT_W'({rand_data() >> 6, 6'($urandom_range(0, 63))}),
                rand_data(), mdata, 100, (i == 2));
    end
  endtask

  // Receiver: random stalls, plus a long hold when a test asks for one
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else if (recv_stall > 0) begin
      out_ch.ready = 1'b0;
      recv_stall--;
    end else begin
      out_ch.ready = 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20) recv_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    seed_t exp_seed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (seed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected seed key=%h pos=%h",
                                  out_ch.seed_key, out_ch.seed_position));
      end else begin
        exp_seed = seed_q.pop_front();
        if (out_ch.seed_key !== exp_seed.key)
          report_mismatch($sformatf("seed_key %h, expected %h", out_ch.seed_key, exp_seed.key));
        if (out_ch.seed_position !== exp_seed.pos)
          report_mismatch($sformatf("seed_position %h, expected %h",
                                    out_ch.seed_position, exp_seed.pos));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no item moved for %0d cycles, %0d seeds pending",
                 idle_cycles, seed_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.base_char = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = kss_pkg::REG_KMER_LENGTH;
    cfg_ch.data     = '0;
    klen_cfg        = kss_pkg::KLEN_RESET;
    conv_cfg        = CONV_NONE;
    modulus_cfg     = kss_pkg::MOD_RESET;
    window          = '0;
    clean_run       = 0;
    base_total      = '0;
    errors          = 0;
    idle_cycles     = 0;
    hold_cycles     = 0;
    recv_stall      = 0;
    no_idle         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_base_decoding();
    test_conversion();
    test_kmer_change();
    test_output_backpressure();
    test_random_streams();
    settle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
